@@ rtl/core/srd_pkg.sv @@
// Shared constants for the shortest route core: default sizes, cost constants
// and command codes. No dependencies.
package srd_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_EDGES    = 64;
    localparam int DEF_LENGTH_BITS  = 10;

    // port field widths
    localparam int VTX_W    = 5;
    localparam int LEN_IN_W = 10;
    localparam int TOTAL_W  = 15;

    // travel time of one edge: STOP_SECONDS + SECONDS_PER_UNIT * length
    localparam int STOP_SECONDS     = 120;
    localparam int SECONDS_PER_UNIT = 40;

    // minutes = 2 * steps + ceil(2 * length / MINUTE_DIVISOR)
    localparam int MINUTE_DIVISOR = 3;

    localparam logic [1:0] CMD_ADD_VERTEX = 2'd0;
    localparam logic [1:0] CMD_ADD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_REACH      = 2'd2;
    localparam logic [1:0] CMD_ROUTE      = 2'd3;

endpackage

@@ rtl/core/shortest_route_dijkstra_core.sv @@
// Shortest route core: station and edge store, sequential Dijkstra search,
// route walk and totals. Depends on srd_pkg and srd_div3.
//
//  channel  dir  tdata (low bit up)                          tuser / tlast
//  s_       in   vertex_a[5] vertex_b[5] edge_length[10]      tuser: cmd[2]
//                use_time[1], 3 zero bits
//  m_       out  found[1] path_vertex[5] total_length[15]     tlast: last
//                total_minutes[15], 4 zero bits
//
// Add commands keep s_tready high. A query runs rounds of a vertex scan and an
// edge scan over the stored edges, one round per settled vertex; the single
// node memory port sets this pace. A route then walks back one station at a
// time, scanning the edges for each step, divides by a reciprocal multiply and
// emits one word per station. s_tready is low from acceptance of a query until
// the last word is taken; m_tready low holds the output word. Reset clears the
// station marks and the edge count; memories are not cleared.
module shortest_route_dijkstra_core
    import srd_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int LENGTH_BITS  = DEF_LENGTH_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // vertex_a, vertex_b, edge_length, use_time, zero fill
    input  logic [1:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // found, path_vertex, total_length, total_minutes, fill
    output logic        m_tlast
);

    localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int PCW  = $clog2(MAX_VERTICES + 1);
    localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int CW   = LENGTH_BITS + 6 + VW;
    localparam int TLW  = LENGTH_BITS + VW;
    localparam int DW   = TLW + 2;
    localparam int EWD  = 2 * VW + LENGTH_BITS;
    localparam int NWD  = VW + CW;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SEL     = 4'd1;
    localparam logic [3:0] ST_SEL_END = 4'd2;
    localparam logic [3:0] ST_ER      = 4'd3;
    localparam logic [3:0] ST_EC      = 4'd4;
    localparam logic [3:0] ST_EU      = 4'd5;
    localparam logic [3:0] ST_PR      = 4'd6;
    localparam logic [3:0] ST_PW      = 4'd7;
    localparam logic [3:0] ST_FR      = 4'd8;
    localparam logic [3:0] ST_FC      = 4'd9;
    localparam logic [3:0] ST_DIV     = 4'd10;
    localparam logic [3:0] ST_OR      = 4'd11;
    localparam logic [3:0] ST_OL      = 4'd12;
    localparam logic [3:0] ST_OW      = 4'd13;

    // input word fields
    logic [VTX_W-1:0]    in_a, in_b;
    logic [LEN_IN_W-1:0] in_len;
    logic                in_time;
    logic [1:0]          in_cmd;
    logic [VW-1:0]       a_idx, b_idx;
    logic                a_ok, b_ok;

    assign in_a    = s_tdata[4:0];
    assign in_b    = s_tdata[9:5];
    assign in_len  = s_tdata[19:10];
    assign in_time = s_tdata[20];
    assign in_cmd  = s_tuser;
    assign a_idx   = VW'(in_a);
    assign b_idx   = VW'(in_b);
    assign a_ok    = (32'(in_a) < MAX_VERTICES);
    assign b_ok    = (32'(in_b) < MAX_VERTICES);

    // control and payload registers
    logic [3:0]              state_reg, state_next;
    logic [MAX_VERTICES-1:0] present_reg, present_next;
    logic [ECW-1:0]          count_reg, count_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [MAX_VERTICES-1:0] settled_reg, settled_next;
    logic [MAX_VERTICES-1:0] pvalid_reg, pvalid_next;
    logic                    out_valid_reg, out_valid_next;

    logic [1:0]           cmd_reg, cmd_next;
    logic [VW-1:0]        dst_reg, dst_next;
    logic                 time_reg, time_next;
    logic [PCW-1:0]       cnt_reg, cnt_next;
    logic                 pend_v_reg, pend_v_next;
    logic [VW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 any_reg, any_next;
    logic [VW-1:0]        u_reg, u_next;
    logic [CW-1:0]        ucost_reg, ucost_next;
    logic [ECW-1:0]       e_reg, e_next;
    logic [VW-1:0]        nxt_reg, nxt_next;
    logic [CW-1:0]        nc_reg, nc_next;
    logic [VW-1:0]        v_reg, v_next;
    logic [VW-1:0]        prev_reg, prev_next;
    logic [PCW-1:0]       n_reg, n_next;
    logic [PCW-1:0]       k_reg, k_next;
    logic [TLW-1:0]       tlen_reg, tlen_next;
    logic [DW-1:0]        min_reg, min_next;
    logic [VW-1:0]        idx_reg, idx_next;
    logic                 o_found_reg, o_found_next;
    logic [VTX_W-1:0]     o_vtx_reg, o_vtx_next;
    logic [TOTAL_W-1:0]   o_len_reg, o_len_next;
    logic [TOTAL_W-1:0]   o_min_reg, o_min_next;
    logic                 o_last_reg, o_last_next;

    // memories
    logic [EWD-1:0] edge_mem [MAX_EDGES];
    logic [NWD-1:0] node_mem [MAX_VERTICES];
    logic [VW-1:0]  path_mem [MAX_VERTICES];
    logic [EWD-1:0] edge_rd;
    logic [NWD-1:0] node_rd;
    logic [VW-1:0]  path_rd;

    logic           edge_we, node_we, path_we;
    logic [EW-1:0]  edge_waddr, edge_raddr;
    logic [EWD-1:0] edge_wdata;
    logic [VW-1:0]  node_waddr, node_raddr;
    logic [NWD-1:0] node_wdata;
    logic [VW-1:0]  path_waddr, path_raddr;
    logic [VW-1:0]  path_wdata;

    // edge word: a in the low bits, then b, then length
    logic [VW-1:0]          ed_a, ed_b;
    logic [LENGTH_BITS-1:0] ed_len;
    logic [CW-1:0]          node_cost, step_cost;
    logic [VW-1:0]          node_pred;

    assign ed_a      = edge_rd[VW-1:0];
    assign ed_b      = edge_rd[2*VW-1:VW];
    assign ed_len    = edge_rd[EWD-1:2*VW];
    assign node_cost = node_rd[CW-1:0];
    assign node_pred = node_rd[NWD-1:CW];
    assign step_cost = time_reg
                     ? CW'(STOP_SECONDS) + CW'(SECONDS_PER_UNIT) * CW'(ed_len)
                     : CW'(ed_len);

    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_q;

    assign div_dividend = (DW'(tlen_reg) << 1) + DW'(2);

    srd_div3 #(.DW(DW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        count_next     = count_reg;
        reached_next   = reached_reg;
        settled_next   = settled_reg;
        pvalid_next    = pvalid_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        dst_next       = dst_reg;
        time_next      = time_reg;
        cnt_next       = cnt_reg;
        pend_v_next    = pend_v_reg;
        pend_idx_next  = pend_idx_reg;
        any_next       = any_reg;
        u_next         = u_reg;
        ucost_next     = ucost_reg;
        e_next         = e_reg;
        nxt_next       = nxt_reg;
        nc_next        = nc_reg;
        v_next         = v_reg;
        prev_next      = prev_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        tlen_next      = tlen_reg;
        min_next       = min_reg;
        idx_next       = idx_reg;
        o_found_next   = o_found_reg;
        o_vtx_next     = o_vtx_reg;
        o_len_next     = o_len_reg;
        o_min_next     = o_min_reg;
        o_last_next    = o_last_reg;

        edge_we    = 1'b0;
        edge_waddr = count_reg[EW-1:0];
        edge_wdata = {LENGTH_BITS'(in_len), b_idx, a_idx};
        edge_raddr = e_reg[EW-1:0];
        node_we    = 1'b0;
        node_waddr = nxt_reg;
        node_wdata = {u_reg, nc_reg};
        node_raddr = cnt_reg[VW-1:0];
        path_we    = 1'b0;
        path_waddr = n_reg[VW-1:0];
        path_wdata = v_reg;
        path_raddr = idx_reg;
        div_start  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_cmd)
                        CMD_ADD_VERTEX:
                        begin
                            if (a_ok)
                                present_next[a_idx] = 1'b1;
                        end
                        CMD_ADD_EDGE:
                        begin
                            if (a_ok && b_ok && present_reg[a_idx] && present_reg[b_idx]
                                && count_reg < ECW'(MAX_EDGES))
                            begin
                                edge_we    = 1'b1;
                                count_next = count_reg + ECW'(1);
                            end
                        end
                        default:
                        begin
                            cmd_next  = in_cmd;
                            dst_next  = b_idx;
                            time_next = (in_cmd == CMD_ROUTE) && in_time;
                            if (!(a_ok && b_ok && present_reg[a_idx] && present_reg[b_idx]))
                            begin
                                out_valid_next = 1'b1;
                                o_found_next   = 1'b0;
                                o_vtx_next     = '0;
                                o_len_next     = '0;
                                o_min_next     = '0;
                                o_last_next    = 1'b1;
                                state_next     = ST_OW;
                            end
                            else
                            begin
                                reached_next        = '0;
                                reached_next[a_idx] = 1'b1;
                                settled_next        = '0;
                                pvalid_next         = '0;
                                node_we             = 1'b1;
                                node_waddr          = a_idx;
                                node_wdata          = '0;
                                cnt_next            = '0;
                                pend_v_next         = 1'b0;
                                any_next            = 1'b0;
                                state_next          = ST_SEL;
                            end
                        end
                    endcase
                end
            end
            ST_SEL:
            begin
                // pick the cheapest open vertex; strict compare keeps the lowest index
                if (pend_v_reg && reached_reg[pend_idx_reg] && !settled_reg[pend_idx_reg]
                    && (!any_reg || node_cost < ucost_reg))
                begin
                    u_next     = pend_idx_reg;
                    ucost_next = node_cost;
                    any_next   = 1'b1;
                end
                if (cnt_reg < PCW'(MAX_VERTICES))
                begin
                    cnt_next      = cnt_reg + PCW'(1);
                    pend_v_next   = 1'b1;
                    pend_idx_next = cnt_reg[VW-1:0];
                end
                else
                begin
                    pend_v_next = 1'b0;
                    state_next  = ST_SEL_END;
                end
            end
            ST_SEL_END:
            begin
                if (!any_reg || u_reg == dst_reg)
                begin
                    if (cmd_reg == CMD_REACH || !reached_reg[dst_reg])
                    begin
                        out_valid_next = 1'b1;
                        o_found_next   = reached_reg[dst_reg];
                        o_vtx_next     = '0;
                        o_len_next     = '0;
                        o_min_next     = '0;
                        o_last_next    = 1'b1;
                        state_next     = ST_OW;
                    end
                    else
                    begin
                        v_next     = dst_reg;
                        n_next     = '0;
                        k_next     = '0;
                        tlen_next  = '0;
                        state_next = ST_PR;
                    end
                end
                else
                begin
                    settled_next[u_reg] = 1'b1;
                    e_next              = '0;
                    state_next          = ST_ER;
                end
            end
            ST_ER:
            begin
                if (e_reg == count_reg)
                begin
                    cnt_next    = '0;
                    pend_v_next = 1'b0;
                    any_next    = 1'b0;
                    state_next  = ST_SEL;
                end
                else
                    state_next = ST_EC;
            end
            ST_EC:
            begin
                nc_next = ucost_reg + step_cost;
                if (ed_a == u_reg || ed_b == u_reg)
                begin
                    nxt_next   = (ed_a == u_reg) ? ed_b : ed_a;
                    node_raddr = (ed_a == u_reg) ? ed_b : ed_a;
                    state_next = ST_EU;
                end
                else
                begin
                    e_next     = e_reg + ECW'(1);
                    state_next = ST_ER;
                end
            end
            ST_EU:
            begin
                if (!reached_reg[nxt_reg] || nc_reg < node_cost)
                begin
                    node_we               = 1'b1;
                    reached_next[nxt_reg] = 1'b1;
                    pvalid_next[nxt_reg]  = 1'b1;
                end
                e_next     = e_reg + ECW'(1);
                state_next = ST_ER;
            end
            ST_PR:
            begin
                node_raddr = v_reg;
                state_next = ST_PW;
            end
            ST_PW:
            begin
                path_we = 1'b1;
                n_next  = n_reg + PCW'(1);
                if (!pvalid_reg[v_reg] || n_reg == PCW'(MAX_VERTICES - 1))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    prev_next  = node_pred;
                    e_next     = '0;
                    k_next     = k_reg + PCW'(1);
                    state_next = ST_FR;
                end
            end
            ST_FR:
            begin
                if (e_reg == count_reg)
                begin
                    v_next     = prev_reg;
                    state_next = ST_PR;
                end
                else
                    state_next = ST_FC;
            end
            ST_FC:
            begin
                // first stored edge joining the pair sets the step length
                if ((ed_a == v_reg && ed_b == prev_reg) || (ed_a == prev_reg && ed_b == v_reg))
                begin
                    tlen_next  = tlen_reg + TLW'(ed_len);
                    v_next     = prev_reg;
                    state_next = ST_PR;
                end
                else
                begin
                    e_next     = e_reg + ECW'(1);
                    state_next = ST_FR;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    min_next   = (DW'(k_reg) << 1) + div_q;
                    idx_next   = VW'(n_reg - PCW'(1));
                    state_next = ST_OR;
                end
            end
            ST_OR:
            begin
                state_next = ST_OL;
            end
            ST_OL:
            begin
                out_valid_next = 1'b1;
                o_found_next   = 1'b1;
                o_vtx_next     = VTX_W'(path_rd);
                o_len_next     = TOTAL_W'(tlen_reg);
                o_min_next     = TOTAL_W'(min_reg);
                o_last_next    = (idx_reg == '0);
                state_next     = ST_OW;
            end
            ST_OW:
            begin
                if (m_tready)
                begin
                    out_valid_next = 1'b0;
                    if (o_last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg - VW'(1);
                        state_next = ST_OR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            count_reg     <= '0;
            reached_reg   <= '0;
            settled_reg   <= '0;
            pvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            count_reg     <= count_next;
            reached_reg   <= reached_next;
            settled_reg   <= settled_next;
            pvalid_reg    <= pvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        dst_reg      <= dst_next;
        time_reg     <= time_next;
        cnt_reg      <= cnt_next;
        pend_v_reg   <= pend_v_next;
        pend_idx_reg <= pend_idx_next;
        any_reg      <= any_next;
        u_reg        <= u_next;
        ucost_reg    <= ucost_next;
        e_reg        <= e_next;
        nxt_reg      <= nxt_next;
        nc_reg       <= nc_next;
        v_reg        <= v_next;
        prev_reg     <= prev_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        tlen_reg     <= tlen_next;
        min_reg      <= min_next;
        idx_reg      <= idx_next;
        o_found_reg  <= o_found_next;
        o_vtx_reg    <= o_vtx_next;
        o_len_reg    <= o_len_next;
        o_min_reg    <= o_min_next;
        o_last_reg   <= o_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_waddr] <= edge_wdata;
        edge_rd <= edge_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        node_rd <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_waddr] <= path_wdata;
        path_rd <= path_mem[path_raddr];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, o_min_reg, o_len_reg, o_vtx_reg, o_found_reg};
    assign m_tlast  = o_last_reg;

endmodule

@@ rtl/core/srd_div3.sv @@
// Division by the constant MINUTE_DIVISOR through a reciprocal multiply, result
// registered in the cycle after start. Depends on srd_pkg.
module srd_div3
    import srd_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [DW-1:0] quotient
);

    // one extra fraction bit keeps the truncation error below a third
    localparam int RW = DW + 1;
    localparam int PW = DW + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RW) + 64'(MINUTE_DIVISOR) - 64'd1) / 64'(MINUTE_DIVISOR));

    logic          done_reg;
    logic [DW-1:0] q_reg;
    logic [PW-1:0] prod;

    assign prod = PW'(dividend) * PW'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            q_reg <= prod[PW-1:RW];
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ tb/shortest_route_dijkstra_core_tb.sv @@
// Testbench for shortest_route_dijkstra_core: builds station graphs, runs reachability and
// route queries, and checks each output word against an in-bench route predictor.
// Depends on srd_pkg and the core RTL.
module shortest_route_dijkstra_core_tb;
    import srd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int NE = DEF_MAX_EDGES;

    typedef struct packed {
        logic                found;
        logic [VTX_W-1:0]    station;
        logic [TOTAL_W-1:0]  length_sum;
        logic [TOTAL_W-1:0]  minutes;
        logic                last;
    } route_word_t;

    class route_scoreboard;
        bit                  present [NV];
        int unsigned         end_a [NE];
        int unsigned         end_b [NE];
        int unsigned         len_of [NE];
        int unsigned         edge_total;
        route_word_t         pending_words [$];
        int                  errors;
        int                  words_checked;
        int                  queries;

        function new();
            edge_total = 0;
            errors = 0;
            words_checked = 0;
            queries = 0;
        endfunction

        function int unsigned first_len(int unsigned p, int unsigned q);
            for (int e = 0; e < edge_total; e++)
            begin
                if ((end_a[e] == p && end_b[e] == q) || (end_a[e] == q && end_b[e] == p))
                    return len_of[e];
            end
            return 0;
        endfunction

        function void push_word(bit f, int unsigned v, int unsigned l, int unsigned m, bit lst);
            route_word_t w;
            w.found = f;
            w.station = v[VTX_W-1:0];
            w.length_sum = l[TOTAL_W-1:0];
            w.minutes = m[TOTAL_W-1:0];
            w.last = lst;
            pending_words.insert(pending_words.size(), w);
        endfunction

        // Predict the words caused by one accepted command.
        function void note_command(logic [1:0] cmd, int unsigned a, int unsigned b,
                                   int unsigned len, bit by_time);
            int unsigned cost [NV];
            int unsigned pred [NV];
            bit          has_pred [NV];
            bit          reached [NV];
            bit          done [NV];
            int unsigned route [$];
            int unsigned u, nxt, nc, v, tl, ts;
            bit          any;
            if (cmd == CMD_ADD_VERTEX)
            begin
                present[a] = 1;
                return;
            end
            if (cmd == CMD_ADD_EDGE)
            begin
                if (present[a] && present[b] && edge_total < NE)
                begin
                    end_a[edge_total] = a;
                    end_b[edge_total] = b;
                    len_of[edge_total] = len;
                    edge_total++;
                end
                return;
            end
            queries++;
            if (!present[a] || !present[b])
            begin
                push_word(0, 0, 0, 0, 1);
                return;
            end
            for (int i = 0; i < NV; i++)
            begin
                cost[i] = 0;
                pred[i] = 0;
                has_pred[i] = 0;
                reached[i] = 0;
                done[i] = 0;
            end
            reached[a] = 1;
            by_time = by_time && (cmd == CMD_ROUTE);
            forever
            begin
                any = 0;
                u = 0;
                for (int i = 0; i < NV; i++)
                    if (reached[i] && !done[i] && (!any || cost[i] < cost[u]))
                    begin
                        u = i;
                        any = 1;
                    end
                if (!any || u == b)
                    break;
                done[u] = 1;
                for (int e = 0; e < edge_total; e++)
                begin
                    if (end_a[e] == u)
                        nxt = end_b[e];
                    else if (end_b[e] == u)
                        nxt = end_a[e];
                    else
                        continue;
                    nc = cost[u] + (by_time ? STOP_SECONDS + SECONDS_PER_UNIT * len_of[e]
                                            : len_of[e]);
                    if (!reached[nxt] || nc < cost[nxt])
                    begin
                        reached[nxt] = 1;
                        cost[nxt] = nc;
                        pred[nxt] = u;
                        has_pred[nxt] = 1;
                    end
                end
            end
            if (cmd == CMD_REACH || !reached[b])
            begin
                push_word(reached[b], 0, 0, 0, 1);
                return;
            end
            // walk back from the destination, then emit source first
            v = b;
            while (route.size() < NV)
            begin
                route.push_front(v);
                if (!has_pred[v])
                    break;
                v = pred[v];
            end
            tl = 0;
            ts = 0;
            for (int i = 0; i + 1 < route.size(); i++)
            begin
                nc = first_len(route[i], route[i+1]);
                tl += nc;
                ts += STOP_SECONDS + SECONDS_PER_UNIT * nc;
            end
            foreach (route[i])
                push_word(1, route[i], tl, (ts + 59) / 60, i == route.size() - 1);
        endfunction

        function void check_word(route_word_t got);
            route_word_t want;
            words_checked++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got.found !== want.found)
                $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
            if (got.station !== want.station)
                $display("%0t: path_vertex exp %0d got %0d", $time, want.station, got.station);
            if (got.length_sum !== want.length_sum)
                $display("%0t: total_length exp %0d got %0d", $time,
                         want.length_sum, got.length_sum);
            if (got.minutes !== want.minutes)
                $display("%0t: total_minutes exp %0d got %0d", $time, want.minutes, got.minutes);
            if (got.last !== want.last)
                $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;  // vertex_a, vertex_b, edge_length, use_time, zero fill
    logic [1:0]  s_tuser = CMD_ADD_VERTEX;  // cmd
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;  // found, path_vertex, total_length, total_minutes, fill
    logic        m_tlast;

    int send_idle = 6;
    int recv_idle = 48;
    route_scoreboard sb = new();

    shortest_route_dijkstra_core i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word({m_tdata[0], m_tdata[5:1], m_tdata[20:6], m_tdata[35:21], m_tlast});

    // tvalid stays high after acceptance; the next send or drain drops or replaces it
    task automatic send(logic [1:0] cmd, int unsigned a, int unsigned b,
                        int unsigned len, bit by_time);
        if ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle)
                @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {3'b0, by_time, len[9:0], b[4:0], a[4:0]};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(cmd, a, b, len, by_time);
    endtask

    task automatic random_commands(int count);
        int unsigned r, len;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
            if (r < 12)
                send(CMD_ADD_VERTEX, $urandom_range(0, 31), 0, $urandom, $urandom);
            else if (r < 55)
                send(CMD_ADD_EDGE, $urandom_range(0, 31), $urandom_range(0, 31), len, $urandom);
            else if (r < 70)
                send(CMD_REACH, $urandom_range(0, 31), $urandom_range(0, 31), $urandom, $urandom);
            else
                send(CMD_ROUTE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom, $urandom);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // empty graph, then stations at both ends of the index range
        send(CMD_ROUTE, 0, 31, 0, 0);
        send(CMD_ADD_VERTEX, 0, 0, 0, 0);
        send(CMD_ADD_VERTEX, 31, 0, 0, 0);
        send(CMD_ADD_VERTEX, 5, 0, 0, 0);
        send(CMD_ADD_VERTEX, 9, 0, 0, 0);
        send(CMD_REACH, 0, 31, 0, 0);
        send(CMD_ROUTE, 31, 31, 0, 1);
        send(CMD_REACH, 5, 5, 0, 0);
        send(CMD_ADD_EDGE, 0, 20, 7, 0);        // absent end, dropped
        send(CMD_ADD_EDGE, 5, 5, 3, 0);         // self loop
        send(CMD_ADD_EDGE, 0, 5, 1023, 0);
        send(CMD_ADD_EDGE, 5, 31, 0, 0);
        send(CMD_ADD_EDGE, 0, 9, 10, 0);
        send(CMD_ADD_EDGE, 9, 31, 10, 0);
        send(CMD_ADD_EDGE, 31, 5, 2, 0);        // parallel edge, later copy
        send(CMD_ROUTE, 0, 31, 0, 0);
        send(CMD_ROUTE, 0, 31, 0, 1);
        send(CMD_ROUTE, 31, 0, 0, 1);
        send(CMD_ADD_EDGE, 9, 5, 1013, 0);      // equal cost tie
        send(CMD_ROUTE, 0, 5, 0, 0);
        send(CMD_ROUTE, 0, 20, 0, 0);
        send(CMD_REACH, 9, 20, 0, 1);
        random_commands(25);
        drain();
        send_idle = 48;
        recv_idle = 6;
        random_commands(25);
        // fill the edge table so later adds are dropped
        while (sb.edge_total < NE)
            send(CMD_ADD_EDGE, 0, 31, $urandom_range(0, 1023), 0);
        drain();
        send_idle = 0;
        recv_idle = 0;
        send(CMD_ADD_EDGE, 0, 9, 1, 0);
        random_commands(25);
        drain();
        $display("Ran %0d queries over %0d stored edges, %0d result words checked.",
                 sb.queries, sb.edge_total, sb.words_checked);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
